FILE: src/lic_pkg.sv
// Shared constants, register codes and the divider bundle type for the
// LED intensity to current and PWM block. Depends on nothing.
package lic_pkg;

    // Widths of the item fields.
    localparam int LEVEL_W = 16;
    localparam int WORD_W  = 32;
    localparam int PWM_W   = 8;
    localparam int CUR_W   = 5;
    localparam int GAIN_W  = 9;

    // Arithmetic constants of the intensity split.
    localparam longint unsigned FULL_SCALE  = 65535;
    localparam longint unsigned STEP_SPAN   = 138543105;
    localparam longint unsigned PWM_DIVISOR = 541185;

    // Number of current steps above the lowest one.
    localparam int CUR_STEPS = 30;

    // Widths inside the pipeline.
    localparam int NUM_W = 32;
    localparam int DIV_W = 24;

    // Quotient bits resolved by one divider stage.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = PWM_W / DIV_BITS_PER_STAGE;

    // High three bits of the LED header byte.
    localparam logic [2:0] HEADER_BITS = 3'b111;

    // Unity gain after reset.
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 9'd256;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_RED_GAIN   = 2'd0,
        REG_GREEN_GAIN = 2'd1,
        REG_BLUE_GAIN  = 2'd2
    } cfg_reg_t;

    // One item on its way through the PWM divider.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DIV_W-1:0] divisor;
        logic [PWM_W-1:0] quo;
        logic [CUR_W-1:0] cur;
    } div_t;

endpackage

FILE: src/led_intensity_to_current_and_pwm_top.sv
// Eight register stages; one item is accepted per cycle while in_stall is low.
// The stages in order: threshold compare, step count, divisor
// multiply, four two-bit divider stages and the colour gain stage.
// Each stage holds its item under stall and empty stages are refilled.
// Reset clears all valid bits and sets the three gains to unity.
// Top level of the LED intensity to current and PWM block.
// Depends on lic_pkg and lic_div_step.
module led_intensity_to_current_and_pwm_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lic_pkg::LEVEL_W-1:0]  light_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lic_pkg::WORD_W-1:0]   led_word,
    output logic [lic_pkg::PWM_W-1:0]    pwm_level,
    output logic [lic_pkg::CUR_W-1:0]    current_level,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [lic_pkg::GAIN_W-1:0]   cfg_data
);
    import lic_pkg::*;

    // Gain registers.
    logic [GAIN_W-1:0] red_gain_reg;
    logic [GAIN_W-1:0] green_gain_reg;
    logic [GAIN_W-1:0] blue_gain_reg;

    // Stage one: level and threshold flags.
    logic                  v1_reg;
    logic [LEVEL_W-1:0]    lvl1_reg;
    logic [CUR_STEPS-1:0]  thermo1_reg;
    logic [CUR_STEPS-1:0]  thermo1_next;
    logic                  en1;

    // Stage two: numerator and current level.
    logic                  v2_reg;
    logic [NUM_W-1:0]      num2_reg;
    logic [NUM_W-1:0]      num2_next;
    logic [CUR_W-1:0]      cur2_reg;
    logic [CUR_W-1:0]      step2;
    logic                  en2;

    // Stage three: divisor for this current level.
    logic                  v3_reg;
    div_t                  d3_reg;
    logic                  en3;

    // Divider chain.
    logic                  dv_valid [DIV_STAGES+1];
    logic                  dv_ready [DIV_STAGES+1];
    div_t                  dv_data  [DIV_STAGES+1];

    // Output stage.
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     led_word_reg;
    logic [PWM_W-1:0]      pwm_reg;
    logic [CUR_W-1:0]      cur_out_reg;
    logic                  en_out;
    logic [WORD_W-1:0]     led_word_next;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg   <= UNITY_GAIN;
            green_gain_reg <= UNITY_GAIN;
            blue_gain_reg  <= UNITY_GAIN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RED_GAIN:   red_gain_reg   <= cfg_data;
                REG_GREEN_GAIN: green_gain_reg <= cfg_data;
                REG_BLUE_GAIN:  blue_gain_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stall chain: a stage moves when it is empty or the next one moves.
    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || dv_ready[0];
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // Current step k is reached when level*65535 >= k*138543105, which is a
    // compare of the level against a rounded-up constant threshold.
    for (genvar k = 1; k <= CUR_STEPS; k++)
    begin : g_thr
        localparam logic [47:0] PROD = 48'(k) * 48'(STEP_SPAN);
        localparam logic [LEVEL_W-1:0] THR =
            LEVEL_W'((PROD + 48'(FULL_SCALE - 1)) / 48'(FULL_SCALE));
        assign thermo1_next[k-1] = (light_level >= THR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            lvl1_reg    <= light_level;
            thermo1_reg <= thermo1_next;
        end
    end

    // The step count q gives current q+1. The divider numerator
    // w + (span-1)*q reduces to level*65535 - q.
    assign step2     = CUR_W'($countones(thermo1_reg));
    assign num2_next = {lvl1_reg, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, lvl1_reg}
                       - {{(NUM_W - CUR_W){1'b0}}, step2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            num2_reg <= num2_next;
            cur2_reg <= step2 + CUR_W'(1);
        end
    end

    // Two floored divisions in a row equal one division by current*541185.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            d3_reg.rem     <= num2_reg;
            d3_reg.divisor <= DIV_W'(cur2_reg) * DIV_W'(PWM_DIVISOR);
            d3_reg.quo     <= '0;
            d3_reg.cur     <= cur2_reg;
        end
    end

    // Divider pipeline, most significant quotient bits first.
    assign dv_valid[0] = v3_reg;
    assign dv_data[0]  = d3_reg;
    assign dv_ready[DIV_STAGES] = en_out;

    for (genvar st = 0; st < DIV_STAGES; st++)
    begin : g_div
        lic_div_step #(
            .BIT_HI(PWM_W - 1 - st * DIV_BITS_PER_STAGE)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv_valid[st]),
            .up_ready (dv_ready[st]),
            .up       (dv_data[st]),
            .dn_valid (dv_valid[st+1]),
            .dn_ready (dv_ready[st+1]),
            .dn       (dv_data[st+1])
        );
    end

    // Colour scaling with saturation to one byte.
    function automatic logic [PWM_W-1:0] scale_colour(
        input logic [PWM_W-1:0]  pwm,
        input logic [GAIN_W-1:0] gain
    );
        logic [PWM_W+GAIN_W-1:0] prod;
        logic [GAIN_W-1:0]       v;
        prod = {{GAIN_W{1'b0}}, pwm} * {{PWM_W{1'b0}}, gain};
        v    = prod[PWM_W+GAIN_W-1:PWM_W];
        return v[GAIN_W-1] ? {PWM_W{1'b1}} : v[PWM_W-1:0];
    endfunction

    assign led_word_next = {
        scale_colour(dv_data[DIV_STAGES].quo, red_gain_reg),
        scale_colour(dv_data[DIV_STAGES].quo, green_gain_reg),
        scale_colour(dv_data[DIV_STAGES].quo, blue_gain_reg),
        HEADER_BITS,
        dv_data[DIV_STAGES].cur
    };

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= dv_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && dv_valid[DIV_STAGES])
        begin
            led_word_reg <= led_word_next;
            pwm_reg      <= dv_data[DIV_STAGES].quo;
            cur_out_reg  <= dv_data[DIV_STAGES].cur;
        end
    end

    assign out_valid     = out_valid_reg;
    assign led_word      = led_word_reg;
    assign pwm_level     = pwm_reg;
    assign current_level = cur_out_reg;

endmodule

FILE: src/lic_div_step.sv
// One registered stage of the restoring divider that produces the PWM level.
// Depends on lic_pkg for the bundle type and the step count.
module lic_div_step #(
    parameter int BIT_HI = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  lic_pkg::div_t up,
    output logic          dn_valid,
    input  logic          dn_ready,
    output lic_pkg::div_t dn
);
    import lic_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    // The stage takes a new item when it is empty or its item moves on.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    // Resolve DIV_BITS_PER_STAGE quotient bits by trial subtraction of the shifted divisor.
    always_comb
    begin
        logic [NUM_W:0] trial;
        logic [NUM_W:0] shifted;
        data_next = up;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            shifted = {{(NUM_W + 1 - DIV_W){1'b0}}, up.divisor} << (BIT_HI - i);
            trial   = {1'b0, data_next.rem} - shifted;
            if (!trial[NUM_W])
            begin
                data_next.rem            = trial[NUM_W-1:0];
                data_next.quo[BIT_HI - i] = 1'b1;
            end
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
